// ===== src/npwr_pkg.sv =====
// Package: shared constants, types and opcodes for the nearest point search block.
package npwr_pkg;

    localparam int TABLE_SLOTS = 64;
    localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
    localparam int COORD_BITS  = 16;

    localparam int OPC_W    = 2;
    localparam int SLOT_W   = 6;
    localparam int RADIUS_W = 16;
    localparam int R2_W     = 2 * RADIUS_W;

    localparam int DX_W     = COORD_BITS + 1;
    localparam int DIST_W   = 2 * DX_W + 1;

    localparam int PIPE_DEPTH = 3;
    localparam int SCAN_END   = TABLE_SLOTS + PIPE_DEPTH;
    localparam int CNT_W      = $clog2(SCAN_END + 1);

    typedef enum logic [OPC_W-1:0] {
        OP_STORE  = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                         live;
        logic [SLOT_BITS-1:0]         slot;
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
    } t_pipe;

endpackage

// ===== src/npwr_if.sv =====
// Interfaces: request and result channels with valid/ready handshake.
interface npwr_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [npwr_pkg::OPC_W-1:0]             opcode;
    logic [npwr_pkg::SLOT_W-1:0]            slot;
    logic signed [npwr_pkg::COORD_BITS-1:0] pos_x;
    logic signed [npwr_pkg::COORD_BITS-1:0] pos_y;
    logic [npwr_pkg::RADIUS_W-1:0]          max_distance;

    modport source (output valid, opcode, slot, pos_x, pos_y, max_distance, input ready);
    modport sink   (input valid, opcode, slot, pos_x, pos_y, max_distance, output ready);
endinterface

interface npwr_res_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   found;
    logic [npwr_pkg::SLOT_W-1:0]            nearest_slot;
    logic signed [npwr_pkg::COORD_BITS-1:0] nearest_x;
    logic signed [npwr_pkg::COORD_BITS-1:0] nearest_y;

    modport source (output valid, found, nearest_slot, nearest_x, nearest_y, input ready);
    modport sink   (input valid, found, nearest_slot, nearest_x, nearest_y, output ready);
endinterface

// ===== src/npwr_dist.sv =====
// Distance unit: pipelined squared distance of one stored point to the query per cycle.
module npwr_dist (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  npwr_pkg::t_pipe                        i_pipe,
    input  logic signed [npwr_pkg::COORD_BITS-1:0] i_qx,
    input  logic signed [npwr_pkg::COORD_BITS-1:0] i_qy,
    output npwr_pkg::t_pipe                        o_pipe,
    output logic [npwr_pkg::DIST_W-1:0]            o_dist
);

    npwr_pkg::t_pipe                   r_s1;
    npwr_pkg::t_pipe                   r_s2;
    logic [npwr_pkg::DX_W-1:0]         r_dx;
    logic [npwr_pkg::DX_W-1:0]         r_dy;
    logic [2*npwr_pkg::DX_W-1:0]       r_sqx;
    logic [2*npwr_pkg::DX_W-1:0]       r_sqy;
    logic signed [npwr_pkg::DX_W:0]    diff_x;
    logic signed [npwr_pkg::DX_W:0]    diff_y;
    logic [npwr_pkg::DX_W:0]           abs_x;
    logic [npwr_pkg::DX_W:0]           abs_y;

    always_comb begin
        diff_x = (npwr_pkg::DX_W+1)'(i_pipe.px) - (npwr_pkg::DX_W+1)'(i_qx);
        diff_y = (npwr_pkg::DX_W+1)'(i_pipe.py) - (npwr_pkg::DX_W+1)'(i_qy);
        abs_x  = diff_x[npwr_pkg::DX_W] ? -diff_x : diff_x;
        abs_y  = diff_y[npwr_pkg::DX_W] ? -diff_y : diff_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.live <= 1'b0;
            r_s2.live <= 1'b0;
        end else begin
            r_s1.live <= i_pipe.live;
            r_s2.live <= r_s1.live;
        end
        r_s1.slot <= i_pipe.slot;
        r_s1.px   <= i_pipe.px;
        r_s1.py   <= i_pipe.py;
        r_dx      <= abs_x[npwr_pkg::DX_W-1:0];
        r_dy      <= abs_y[npwr_pkg::DX_W-1:0];
        r_s2.slot <= r_s1.slot;
        r_s2.px   <= r_s1.px;
        r_s2.py   <= r_s1.py;
        r_sqx     <= r_dx * r_dx;
        r_sqy     <= r_dy * r_dy;
    end

    assign o_pipe = r_s2;
    assign o_dist = npwr_pkg::DIST_W'(r_sqx) + npwr_pkg::DIST_W'(r_sqy);

endmodule

// ===== src/nearest_point_within_radius.sv =====
// Top level: point table, slot scan sequencer and best-candidate tracking.
//
//  channel | dir | handshake     | payload
//  i_req   | in  | valid/ready   | opcode, slot, pos_x, pos_y, max_distance
//  o_res   | out | valid/ready   | found, nearest_slot, nearest_x, nearest_y
//
// Store, remove and unused opcodes do not scan; a result beat follows.
// A query scans all TABLE_SLOTS slots, one per cycle, through the distance unit;
// the result is loaded in ST_DONE once the scan counter reaches SCAN_END.
// Synchronous reset clears the valid marks; the coordinate memory is not cleared.
// A stalled result holds o_res and blocks the next request until taken.
module nearest_point_within_radius (
    input  logic       i_clk,
    input  logic       i_rst_n,
    npwr_req_if.sink   i_req,
    npwr_res_if.source o_res
);

    npwr_pkg::t_state                     r_state;
    npwr_pkg::t_state                     n_state;
    logic [npwr_pkg::CNT_W-1:0]           r_cnt;
    logic [npwr_pkg::TABLE_SLOTS-1:0]     r_valid;
    logic [2*npwr_pkg::COORD_BITS-1:0]    r_mem [npwr_pkg::TABLE_SLOTS];
    npwr_pkg::t_pipe                      r_rd;
    logic signed [npwr_pkg::COORD_BITS-1:0] r_qx;
    logic signed [npwr_pkg::COORD_BITS-1:0] r_qy;
    logic [npwr_pkg::R2_W-1:0]            r_r2;
    logic                                 r_found;
    logic [npwr_pkg::DIST_W-1:0]          r_best_d;
    logic [npwr_pkg::SLOT_BITS-1:0]       r_best_slot;
    logic signed [npwr_pkg::COORD_BITS-1:0] r_best_x;
    logic signed [npwr_pkg::COORD_BITS-1:0] r_best_y;
    logic                                 r_out_valid;
    logic                                 r_out_found;
    logic [npwr_pkg::SLOT_W-1:0]          r_out_slot;
    logic signed [npwr_pkg::COORD_BITS-1:0] r_out_x;
    logic signed [npwr_pkg::COORD_BITS-1:0] r_out_y;

    logic                                 req_ready;
    logic                                 req_beat;
    logic                                 res_beat;
    logic                                 slot_ok;
    logic [npwr_pkg::SLOT_BITS-1:0]       wr_slot;
    logic                                 is_store;
    logic                                 is_remove;
    logic                                 is_query;
    logic                                 scan_issue;
    logic                                 scan_last;
    logic                                 load_out;
    logic [npwr_pkg::SLOT_BITS-1:0]       rd_addr;
    npwr_pkg::t_pipe                      dist_pipe;
    logic [npwr_pkg::DIST_W-1:0]          sq_dist;
    logic                                 take;

    assign req_beat  = i_req.valid && i_req.ready;
    assign res_beat  = o_res.valid && o_res.ready;
    assign slot_ok   = 32'(i_req.slot) < npwr_pkg::TABLE_SLOTS;
    assign wr_slot   = npwr_pkg::SLOT_BITS'(i_req.slot);
    assign is_store  = npwr_pkg::t_opcode'(i_req.opcode) == npwr_pkg::OP_STORE;
    assign is_remove = npwr_pkg::t_opcode'(i_req.opcode) == npwr_pkg::OP_REMOVE;
    assign is_query  = npwr_pkg::t_opcode'(i_req.opcode) == npwr_pkg::OP_QUERY;
    assign rd_addr   = r_cnt[npwr_pkg::SLOT_BITS-1:0];
    assign scan_last = r_cnt == npwr_pkg::CNT_W'(npwr_pkg::SCAN_END);

    always_comb begin
        n_state = r_state;
        case (r_state)
            npwr_pkg::ST_IDLE: begin
                if (req_beat && is_query) begin
                    n_state = npwr_pkg::ST_SCAN;
                end
            end
            npwr_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = npwr_pkg::ST_DONE;
                end
            end
            npwr_pkg::ST_DONE: n_state = npwr_pkg::ST_IDLE;
            default:           n_state = npwr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        req_ready  = 1'b0;
        scan_issue = 1'b0;
        load_out   = 1'b0;
        case (r_state)
            npwr_pkg::ST_IDLE: req_ready  = !r_out_valid || o_res.ready;
            npwr_pkg::ST_SCAN: scan_issue = 32'(r_cnt) < npwr_pkg::TABLE_SLOTS;
            npwr_pkg::ST_DONE: load_out   = 1'b1;
            default: begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign i_req.ready = req_ready;

    always_ff @(posedge i_clk) begin
        if (req_beat && is_store && slot_ok) begin
            r_mem[wr_slot] <= {i_req.pos_y, i_req.pos_x};
        end
        r_rd.px <= r_mem[rd_addr][npwr_pkg::COORD_BITS-1:0];
        r_rd.py <= r_mem[rd_addr][2*npwr_pkg::COORD_BITS-1:npwr_pkg::COORD_BITS];
        r_rd.slot <= rd_addr;
        if (!i_rst_n) begin
            r_rd.live <= 1'b0;
        end else begin
            r_rd.live <= scan_issue && r_valid[rd_addr];
        end
    end

    npwr_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pipe  (r_rd),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .o_pipe  (dist_pipe),
        .o_dist  (sq_dist)
    );

    assign take = dist_pipe.live && (r_state == npwr_pkg::ST_SCAN)
               && (sq_dist <= npwr_pkg::DIST_W'(r_r2)) && (sq_dist <= r_best_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= npwr_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_valid     <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            if (req_beat) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
                if (is_store && slot_ok) begin
                    r_valid[wr_slot] <= 1'b1;
                end else if (is_remove && slot_ok) begin
                    r_valid[wr_slot] <= 1'b0;
                end
            end else if (r_state == npwr_pkg::ST_SCAN) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (take) begin
                r_found <= 1'b1;
            end
            if ((req_beat && !is_query) || load_out) begin
                r_out_valid <= 1'b1;
            end else if (res_beat) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_beat) begin
            r_qx     <= i_req.pos_x;
            r_qy     <= i_req.pos_y;
            r_r2     <= i_req.max_distance * i_req.max_distance;
            r_best_d <= '1;
        end else if (take) begin
            r_best_d    <= sq_dist;
            r_best_slot <= dist_pipe.slot;
            r_best_x    <= dist_pipe.px;
            r_best_y    <= dist_pipe.py;
        end
        if (req_beat && !is_query) begin
            r_out_found <= 1'b0;
            r_out_slot  <= '0;
            r_out_x     <= '0;
            r_out_y     <= '0;
        end else if (load_out) begin
            r_out_found <= r_found;
            r_out_slot  <= r_found ? npwr_pkg::SLOT_W'(r_best_slot) : '0;
            r_out_x     <= r_found ? r_best_x : '0;
            r_out_y     <= r_found ? r_best_y : '0;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.found        = r_out_found;
    assign o_res.nearest_slot = r_out_slot;
    assign o_res.nearest_x    = r_out_x;
    assign o_res.nearest_y    = r_out_y;

    a_no_result_during_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == npwr_pkg::ST_SCAN) |-> !r_out_valid)
        else $error("result beat pending while scanning");

    a_found_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_found) |-> r_valid[npwr_pkg::SLOT_BITS'(r_out_slot)])
        else $error("reported slot is not valid");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == npwr_pkg::ST_SCAN) |-> (32'(r_cnt) <= npwr_pkg::SCAN_END))
        else $error("scan counter overran");

    a_done_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == npwr_pkg::ST_DONE) |=> r_out_valid)
        else $error("query finished without result beat");

endmodule
